/* rtl/assert_macros.svh */
// Assertion macros used by the RTL datapath module. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mlpm_pkg.sv */
package mlpm_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FS_W     = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OFF_W    = 7;
  localparam int unsigned PLEN_W   = 12;

  localparam logic [PLEN_W-1:0] MAX_PATH_BYTES = 12'd4095;
  localparam logic [BYTE_W-1:0] SLASH_BYTE     = 8'h2F;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_ADDED     = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_MNT_LONG  = 3'd2;
  localparam status_t ST_MATCHED   = 3'd3;
  localparam status_t ST_NO_MATCH  = 3'd4;
  localparam status_t ST_PATH_LONG = 3'd5;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] path_byte;
    logic              last;
    logic [FS_W-1:0]   fs_id;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [FS_W-1:0]   matched_fs;
    logic [OFF_W-1:0]  subpath_offset;
    logic [PLEN_W-1:0] subpath_length;
  } out_item_t;

  typedef struct packed {
    logic    take_byte;
    logic    clear_scan;
    logic    issue_rd;
    logic    wr_row;
    logic    load_out;
    status_t res_code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic too_long;
    logic ovf;
    logic count_zero;
    logic scan_done;
    logic found;
    logic out_busy;
  } dp_sts_t;

endpackage

/* rtl/mlpm_ctrl.sv */
module mlpm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_last,
  input  logic                  in_kind,
  output logic                  in_stall,
  input  mlpm_pkg::dp_sts_t     sts,
  output mlpm_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ADD    = 6'b000010,
    S_MATCH  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  mlpm_pkg::status_t res_r, res_nxt;

  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    cmd            = '0;
    cmd.res_code   = res_r;
    in_stall       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall      = 1'b0;
        cmd.take_byte = in_valid;
        if (in_valid && in_last) begin
          state_nxt = in_kind ? S_MATCH : S_ADD;
        end
      end
      S_ADD: begin
        state_nxt = S_RESULT;
        priority if (sts.full) begin
          res_nxt = mlpm_pkg::ST_FULL;
        end else if (sts.too_long) begin
          res_nxt = mlpm_pkg::ST_MNT_LONG;
        end else begin
          res_nxt    = mlpm_pkg::ST_ADDED;
          cmd.wr_row = 1'b1;
        end
      end
      S_MATCH: begin
        if (sts.ovf) begin
          res_nxt   = mlpm_pkg::ST_PATH_LONG;
          state_nxt = S_RESULT;
        end else begin
          res_nxt        = mlpm_pkg::ST_NO_MATCH;
          cmd.clear_scan = 1'b1;
          state_nxt      = sts.count_zero ? S_RESULT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue_rd = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (res_r == mlpm_pkg::ST_NO_MATCH && sts.found) begin
          cmd.res_code = mlpm_pkg::ST_MATCHED;
        end
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= mlpm_pkg::ST_ADDED;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

/* rtl/mlpm_dpath.sv */
`include "assert_macros.svh"

module mlpm_dpath #(
  parameter int unsigned MOUNTS           = 256,
  parameter int unsigned MOUNT_PATH_BYTES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mlpm_pkg::in_item_t    in_item,
  input  logic                  out_stall,
  output logic                  out_valid,
  output mlpm_pkg::out_item_t   out_item,
  input  mlpm_pkg::ctrl_cmd_t   cmd,
  output mlpm_pkg::dp_sts_t     sts
);

  localparam int unsigned AW      = $clog2(MOUNTS);
  localparam int unsigned COUNT_W = $clog2(MOUNTS + 1);
  localparam int unsigned LEN_W   = $clog2(MOUNT_PATH_BYTES);
  localparam int unsigned BYTES_W = MOUNT_PATH_BYTES * mlpm_pkg::BYTE_W;
  localparam int unsigned ROW_W   = BYTES_W + LEN_W + mlpm_pkg::FS_W;
  localparam int unsigned PW      = mlpm_pkg::PLEN_W;
  localparam int unsigned OW      = mlpm_pkg::OFF_W;

  logic [MOUNT_PATH_BYTES-1:0][mlpm_pkg::BYTE_W-1:0] path_buf_r;
  logic [PW-1:0]                byte_cnt_r, byte_cnt_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [PW-1:0]                plen_r;
  logic                         ovf_l_r;
  logic [mlpm_pkg::FS_W-1:0]    fs_r;
  logic [COUNT_W-1:0]           mount_count_r;
  logic [AW-1:0]                rd_addr_r;
  logic                         cmp_valid_r;
  logic [ROW_W-1:0]             rdata_r;
  logic [LEN_W-1:0]             best_r;
  logic                         found_r;
  logic [mlpm_pkg::FS_W-1:0]    win_fs_r;
  logic                         out_valid_r;
  mlpm_pkg::out_item_t          out_item_r, out_item_nxt;

  logic [ROW_W-1:0] mount_mem [MOUNTS];

  logic [MOUNT_PATH_BYTES-1:0] neq_vec;
  logic [MOUNT_PATH_BYTES-1:0] len_mask;
  logic [LEN_W-1:0]            row_len;
  logic [mlpm_pkg::FS_W-1:0]   row_fs;
  logic                        prefix_ok;
  logic                        take_row;
  logic                        slash_skip;
  logic [OW-1:0]               sub_off;
  logic                        at_limit;

  assign at_limit     = byte_cnt_r >= mlpm_pkg::MAX_PATH_BYTES;
  assign byte_cnt_nxt = at_limit ? byte_cnt_r : byte_cnt_r + PW'(1);
  assign ovf_nxt      = ovf_r | at_limit;

  always_ff @(posedge clk) begin
    if (cmd.take_byte && byte_cnt_r < PW'(MOUNT_PATH_BYTES)) begin
      path_buf_r[byte_cnt_r[LEN_W-1:0]] <= in_item.path_byte;
    end
    if (cmd.take_byte && in_item.last) begin
      plen_r  <= byte_cnt_nxt;
      ovf_l_r <= ovf_nxt;
      fs_r    <= in_item.fs_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      ovf_r      <= 1'b0;
    end else if (cmd.take_byte) begin
      if (in_item.last) begin
        byte_cnt_r <= '0;
        ovf_r      <= 1'b0;
      end else begin
        byte_cnt_r <= byte_cnt_nxt;
        ovf_r      <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_row) begin
      mount_mem[mount_count_r[AW-1:0]] <= {fs_r, plen_r[LEN_W-1:0], path_buf_r};
    end
    if (cmd.issue_rd) begin
      rdata_r <= mount_mem[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mount_count_r <= '0;
    end else if (cmd.wr_row) begin
      mount_count_r <= mount_count_r + COUNT_W'(1);
    end
  end

  assign row_len = rdata_r[BYTES_W +: LEN_W];
  assign row_fs  = rdata_r[BYTES_W + LEN_W +: mlpm_pkg::FS_W];

  always_comb begin
    for (int k = 0; k < MOUNT_PATH_BYTES; k++) begin
      neq_vec[k]  = rdata_r[k*mlpm_pkg::BYTE_W +: mlpm_pkg::BYTE_W] != path_buf_r[k];
      len_mask[k] = LEN_W'(k) < row_len;
    end
  end

  assign prefix_ok = ~|(neq_vec & len_mask);
  assign take_row  = cmp_valid_r && prefix_ok && (PW'(row_len) <= plen_r)
                     && (row_len > best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r   <= '0;
      cmp_valid_r <= 1'b0;
      best_r      <= '0;
      found_r     <= 1'b0;
    end else begin
      cmp_valid_r <= cmd.issue_rd;
      if (cmd.clear_scan) begin
        rd_addr_r <= '0;
        best_r    <= '0;
        found_r   <= 1'b0;
      end else begin
        if (cmd.issue_rd) begin
          rd_addr_r <= rd_addr_r + AW'(1);
        end
        if (take_row) begin
          best_r  <= row_len;
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_row && !cmd.clear_scan) begin
      win_fs_r <= row_fs;
    end
  end

  assign slash_skip = (PW'(best_r) < plen_r) && (path_buf_r[best_r] == mlpm_pkg::SLASH_BYTE);
  assign sub_off    = OW'(best_r) + OW'(slash_skip);

  always_comb begin
    out_item_nxt        = '0;
    out_item_nxt.status = cmd.res_code;
    if (cmd.res_code == mlpm_pkg::ST_MATCHED || cmd.res_code == mlpm_pkg::ST_NO_MATCH) begin
      out_item_nxt.matched_fs     = found_r ? win_fs_r : '0;
      out_item_nxt.subpath_offset = sub_off;
      out_item_nxt.subpath_length = plen_r - PW'(sub_off);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign sts.full       = mount_count_r >= COUNT_W'(MOUNTS);
  assign sts.too_long   = ovf_l_r || (plen_r > PW'(MOUNT_PATH_BYTES - 1));
  assign sts.ovf        = ovf_l_r;
  assign sts.count_zero = mount_count_r == '0;
  assign sts.scan_done  = (COUNT_W'(rd_addr_r) + COUNT_W'(1)) == mount_count_r;
  assign sts.found      = found_r;
  assign sts.out_busy   = out_valid_r && out_stall;

  `ASSERT_SAME(a_no_write_when_full, cmd.wr_row, mount_count_r < COUNT_W'(MOUNTS),
               "mount written into a full table")
  `ASSERT_SAME(a_read_in_range, cmd.issue_rd, COUNT_W'(rd_addr_r) < mount_count_r,
               "scan read beyond the last mount")
  `ASSERT_SAME(a_load_when_free, cmd.load_out, !(out_valid_r && out_stall),
               "result overwrote a stalled result")
  `ASSERT_SAME(a_counter_idle_at_result, cmd.load_out, byte_cnt_r == '0 && !ovf_r,
               "byte counter not cleared when the result is issued")

endmodule

/* rtl/mount_longest_prefix_match_top.sv */
// Mount table with longest-prefix lookup.
// Input channel (in_valid, in_stall, in_item): one path byte per request. A request with
// last set ends the path; kind on that final request selects add (0) or match (1), and
// fs_id on it gives the filesystem id of an added mount.
// Output channel (out_valid, out_stall, out_item): exactly one result per completed path.
// Non-final bytes are taken one per cycle. After a final byte the block stalls its input
// until its result is loaded: an add passes through the add and result states, a match
// through the match, scan, drain and result states, where the scan reads each stored
// mount row, one per cycle, from the mount memory and compares the whole row at once.
// A match against an empty table, or of an over-long path, skips the scan.
// The result sits in an output register. Further bytes are accepted while it waits; only
// the next final byte waits in the result state until the register is free, so a stalled
// receiver holds back the input after at most one more path.
// Reset empties the table and clears the byte counter; stored mount rows are not cleared
// and need no clearing pass.
module mount_longest_prefix_match_top #(
  parameter int unsigned MOUNTS           = 256,
  parameter int unsigned MOUNT_PATH_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mlpm_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mlpm_pkg::out_item_t  out_item
);

  mlpm_pkg::ctrl_cmd_t cmd;
  mlpm_pkg::dp_sts_t   sts;

  mlpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_item.last),
    .in_kind  (in_item.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlpm_dpath #(
    .MOUNTS           (MOUNTS),
    .MOUNT_PATH_BYTES (MOUNT_PATH_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* verif/mount_longest_prefix_match_top_tb.sv */
`timescale 1ns / 1ps
module mount_longest_prefix_match_top_tb;

  localparam int unsigned MOUNTS           = 256;
  localparam int unsigned MOUNT_PATH_BYTES = 64;
  localparam logic        KIND_ADD         = 1'b0;
  localparam logic        KIND_MATCH       = 1'b1;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned DRAIN_CYCLES     = MOUNTS + 40;
  localparam int unsigned RANDOM_ITEMS     = 640;
  localparam int unsigned REPORT_LIMIT     = 10;

  class mount_table_scoreboard;
    logic [7:0]  mnt_path [MOUNTS][MOUNT_PATH_BYTES];
    int unsigned mnt_len [MOUNTS];
    logic [7:0]  mnt_fs [MOUNTS];
    int unsigned mount_count;
    logic [7:0]  path_buf [MOUNT_PATH_BYTES];
    int unsigned byte_cnt;
    bit          overflow;
    mlpm_pkg::out_item_t expected_results [$];
    int unsigned failures;

    function void note_request(mlpm_pkg::in_item_t req);
      mlpm_pkg::out_item_t res;
      int unsigned plen;
      int unsigned best;
      int unsigned winner;
      int unsigned i;
      int unsigned j;
      bit          found;
      bit          hit;
      if (byte_cnt < MOUNT_PATH_BYTES) path_buf[byte_cnt] = req.path_byte;
      if (byte_cnt >= mlpm_pkg::MAX_PATH_BYTES) overflow = 1'b1;
      else byte_cnt++;
      if (!req.last) return;
      plen = byte_cnt;
      res  = '0;
      if (req.kind == KIND_ADD) begin
        if (mount_count >= MOUNTS) begin
          res.status = mlpm_pkg::ST_FULL;
        end else if (overflow || plen > MOUNT_PATH_BYTES - 1) begin
          res.status = mlpm_pkg::ST_MNT_LONG;
        end else begin
          for (j = 0; j < plen; j++) mnt_path[mount_count][j] = path_buf[j];
          mnt_len[mount_count] = plen;
          mnt_fs[mount_count]  = req.fs_id;
          mount_count++;
          res.status = mlpm_pkg::ST_ADDED;
        end
      end else if (overflow) begin
        res.status = mlpm_pkg::ST_PATH_LONG;
      end else begin
        best   = 0;
        winner = 0;
        found  = 1'b0;
        for (i = 0; i < mount_count; i++) begin
          if (mnt_len[i] > plen || mnt_len[i] <= best) continue;
          hit = 1'b1;
          for (j = 0; j < mnt_len[i]; j++)
            if (mnt_path[i][j] != path_buf[j]) hit = 1'b0;
          if (hit) begin
            best   = mnt_len[i];
            winner = i;
            found  = 1'b1;
          end
        end
        // A single slash after the prefix is skipped, but only if the path goes on.
        if (best < plen && best < MOUNT_PATH_BYTES && path_buf[best] == mlpm_pkg::SLASH_BYTE)
          best++;
        res.status         = found ? mlpm_pkg::ST_MATCHED : mlpm_pkg::ST_NO_MATCH;
        res.matched_fs     = found ? mnt_fs[winner] : '0;
        res.subpath_offset = best[mlpm_pkg::OFF_W-1:0];
        plen               = plen - best;
        res.subpath_length = plen[mlpm_pkg::PLEN_W-1:0];
      end
      byte_cnt = 0;
      overflow = 1'b0;
      expected_results.push_back(res);
    endfunction

    function void report_bad(string what, mlpm_pkg::out_item_t want,
                             mlpm_pkg::out_item_t got);
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("%0t: %s: expected st=%0d fs=%0d off=%0d len=%0d",
                 $time, what, want.status, want.matched_fs, want.subpath_offset,
                 want.subpath_length);
        $display("    got st=%0d fs=%0d off=%0d len=%0d",
                 got.status, got.matched_fs, got.subpath_offset, got.subpath_length);
      end
    endfunction

    function void check_result(mlpm_pkg::out_item_t got);
      mlpm_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        report_bad("result without a pending request", '0, got);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.matched_fs !== want.matched_fs ||
          got.subpath_offset !== want.subpath_offset ||
          got.subpath_length !== want.subpath_length)
        report_bad("result mismatch", want, got);
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  mlpm_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mlpm_pkg::out_item_t out_item;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  logic        hold_armed         = 1'b0;
  bit          hold_done          = 1'b0;
  int unsigned hold_left          = 0;
  int unsigned items_sent         = 0;
  logic [7:0]  stream [$];
  logic [7:0]  longest_mount [$];
  int unsigned idle_plan [4]      = '{0, 47, 0, 9};
  int unsigned stall_plan [4]     = '{0, 0, 47, 9};

  mount_table_scoreboard sb = new();

  mount_longest_prefix_match_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // The long hold-off lets the sender run on until the block refuses further requests.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  function automatic logic [7:0] path_char();
    int unsigned r = $urandom_range(99);
    if (r < 35) return mlpm_pkg::SLASH_BYTE;
    if (r < 85) return 8'h61 + 8'($urandom_range(2));
    return 8'($urandom_range(255));
  endfunction

  task automatic add_chars(input int unsigned n);
    repeat (n) stream.push_back(path_char());
  endtask

  task automatic load_mount(input bit whole);
    int unsigned idx = $urandom_range(sb.mount_count - 1);
    int unsigned n   = whole ? sb.mnt_len[idx] : $urandom_range(1, sb.mnt_len[idx]);
    stream.delete();
    for (int unsigned k = 0; k < n; k++) stream.push_back(sb.mnt_path[idx][k]);
  endtask

  task automatic send_stream(input logic kind, input logic [7:0] fs);
    mlpm_pkg::in_item_t req;
    int unsigned        i;
    for (i = 0; i < stream.size(); i++) begin
      req.last      = (i == stream.size() - 1);
      req.kind      = req.last ? kind : 1'($urandom_range(1));
      req.path_byte = stream[i];
      req.fs_id     = req.last ? fs : 8'($urandom_range(255));
      while ($urandom_range(99) < sender_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_item  <= req;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      items_sent++;
    end
  endtask

  task automatic send_text(input logic kind, input logic [7:0] fs, input string s);
    stream.delete();
    for (int k = 0; k < s.len(); k++) stream.push_back(s[k]);
    send_stream(kind, fs);
  endtask

  task automatic random_stream();
    int unsigned r = $urandom_range(99);
    stream.delete();
    if (r < 40) begin
      if (sb.mount_count != 0 && $urandom_range(1)) begin
        load_mount(1'b1);
        if ($urandom_range(3) != 0) stream.push_back(mlpm_pkg::SLASH_BYTE);
        add_chars($urandom_range(0, 3));
      end else begin
        add_chars($urandom_range(1, 4));
      end
      if ($urandom_range(49) == 0) begin
        stream.delete();
        add_chars($urandom_range(60, 66));
      end
      send_stream(KIND_ADD, 8'($urandom_range(255)));
    end else if (r < 90) begin
      if (sb.mount_count != 0 && $urandom_range(4) != 0) begin
        load_mount($urandom_range(3) != 0);
        if ($urandom_range(1)) stream.push_back(mlpm_pkg::SLASH_BYTE);
        add_chars($urandom_range(0, 4));
      end else begin
        add_chars($urandom_range(1, 6));
      end
      if ($urandom_range(49) == 0) add_chars($urandom_range(55, 70));
      send_stream(KIND_MATCH, 8'($urandom_range(255)));
    end else begin
      add_chars($urandom_range(1, 8));
      send_stream(1'($urandom_range(1)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text(KIND_MATCH, 8'h00, "/x");
    send_text(KIND_ADD, 8'hFF, "/");
    send_text(KIND_ADD, 8'h00, "/a");
    send_text(KIND_ADD, 8'h77, "/a");
    send_text(KIND_MATCH, 8'hFF, "/a/b");
    send_text(KIND_MATCH, 8'h12, "/a");
    send_text(KIND_MATCH, 8'h34, "/ab");
    send_text(KIND_MATCH, 8'h56, "b");
    stream.delete();
    stream.push_back(8'h00);
    stream.push_back(8'hFF);
    send_stream(KIND_MATCH, 8'hA5);

    // The longest mount accepted, one byte more, and a path running past it.
    stream.delete();
    add_chars(MOUNT_PATH_BYTES - 1);
    longest_mount = stream;
    send_stream(KIND_ADD, 8'h3C);
    stream = longest_mount;
    stream.push_back(8'hAB);
    send_stream(KIND_ADD, 8'hC3);
    stream = longest_mount;
    stream.push_back(mlpm_pkg::SLASH_BYTE);
    add_chars(3);
    send_stream(KIND_MATCH, 8'h00);

    for (phase = 0; phase < 4; phase++) begin
      sender_idle_pct    <= idle_plan[phase];
      receiver_stall_pct <= stall_plan[phase];
      if (phase == 0) hold_armed <= 1'b1;
      phase_end = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < phase_end) random_stream();
    end

    while (sb.mount_count < MOUNTS) begin
      stream.delete();
      add_chars($urandom_range(1, 2));
      send_stream(KIND_ADD, 8'($urandom_range(255)));
    end
    stream.delete();
    add_chars(2);
    send_stream(KIND_ADD, 8'($urandom_range(255)));
    stream.delete();
    add_chars(MOUNT_PATH_BYTES);
    send_stream(KIND_ADD, 8'($urandom_range(255)));
    repeat (24) random_stream();

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_results.size() == 0) begin
      $display("** mount_longest_prefix_match_top: PASSED **");
    end else begin
      $display("** mount_longest_prefix_match_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timed out waiting for the block.");
    $display("** mount_longest_prefix_match_top: FAILED **");
    $finish;
  end

endmodule
